FILE: src/ghash_authenticator_defines.svh
// ----------------------------------------------------------------------------
// GHASH authenticator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef GHASH_AUTHENTICATOR_DEFINES_SVH
`define GHASH_AUTHENTICATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define GHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gha_pkg.sv
// ----------------------------------------------------------------------------
// GHASH authenticator package
// Types, constants and helpers shared by the GHASH engine modules.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned BlockBits  = 128;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned HalfBits   = 64;
  localparam int unsigned TotalBits  = 61;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned BitsPerCyc = 8;
  localparam int unsigned StepBits   = 4;

  // Reduction byte of R = 0xE1 || 0^120
  localparam logic [7:0] ReduceByte = 8'hE1;

  localparam logic [CountBits-1:0] FullCount = 5'd16;
  localparam logic [TotalBits-1:0] TotalMax  = {TotalBits{1'b1}};

  // Configuration register indexes
  localparam logic CfgKeyHi = 1'b0;
  localparam logic CfgKeyLo = 1'b1;

  // Request to the multiplier
  typedef struct packed {
    logic                 start;
    logic [BlockBits-1:0] x;
  } mul_req_t;

  // Response from the multiplier
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [BlockBits-1:0] z;
  } mul_rsp_t;

  // Keep the leading n bytes of a block (byte 0 in the top bits), zero the rest
  function automatic logic [BlockBits-1:0] byte_mask(input logic [CountBits-1:0] n);
    logic [BlockBits-1:0] m;
    m = '0;
    for (int i = 0; i < BlockBytes; i++) begin
      if (CountBits'(i) < n) begin
        m[BlockBits-1-8*i -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Saturating add of a byte count to a section total
  function automatic logic [TotalBits-1:0] sat_add(input logic [TotalBits-1:0] total,
                                                   input logic [CountBits-1:0] n);
    logic [TotalBits:0] sum;
    sum = {1'b0, total} + {{(TotalBits+1-CountBits){1'b0}}, n};
    return sum[TotalBits] ? TotalMax : sum[TotalBits-1:0];
  endfunction

endpackage

FILE: src/ghash_authenticator.sv
// ----------------------------------------------------------------------------
// GHASH authenticator
// GCM GHASH engine over GF(2^128) with length block and per-section counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid_i/in_ready_o) carry one block of up to 16 bytes,
//   its section and a last mark. The hash subkey is written through the
//   cfg port (index 0 upper half, index 1 lower half); the user must write
//   it only while the block idles, which the block itself does not enforce.
//   Each multiply by H runs on one shared unit, eight bits of X per cycle,
//   and a registered done flag hands the product back. in_ready_o is high
//   only while idle. A last beat with data adds a second multiply for the
//   length block; an empty last beat runs only the length multiply. An
//   empty beat that is not last is absorbed with no multiply.
//   Result beats (out_valid_o/out_ready_i) carry the tag from an output
//   register; a stalled receiver holds the tag, and a later finished tag
//   waits in the engine until the register frees.
//   Reset clears the accumulator, the byte counters and the subkey. After
//   each tag the accumulator and counters clear for the next message.
// ----------------------------------------------------------------------------
`include "ghash_authenticator_defines.svh"

module ghash_authenticator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [gha_pkg::HalfBits-1:0]  cfg_wdata_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gha_pkg::HalfBits-1:0]  data_hi_i,
  input  logic [gha_pkg::HalfBits-1:0]  data_lo_i,
  input  logic [gha_pkg::CountBits-1:0] byte_count_i,
  input  logic                          section_i,
  input  logic                          is_last_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gha_pkg::HalfBits-1:0]  tag_hi_o,
  output logic [gha_pkg::HalfBits-1:0]  tag_lo_o
);
  import gha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_MUL_DATA = 4'b0010,
    ST_MUL_LEN  = 4'b0100,
    ST_EMIT     = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [BlockBits-1:0] acc_q, acc_d;
  logic [TotalBits-1:0] aad_q, aad_d;
  logic [TotalBits-1:0] text_q, text_d;
  logic                 last_q, last_d;
  logic [HalfBits-1:0]  key_hi_q, key_lo_q;
  logic [BlockBits-1:0] tag_q, tag_d;
  logic                 out_valid_q, out_valid_d;

  logic                 in_accept;
  logic [CountBits-1:0] n_clip;
  logic [BlockBits-1:0] blk;
  logic [BlockBits-1:0] len_blk;
  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Clip oversized counts and zero the unused bytes
  assign n_clip  = (byte_count_i > FullCount) ? FullCount : byte_count_i;
  assign blk     = {data_hi_i, data_lo_i} & byte_mask(n_clip);
  assign len_blk = {aad_q, 3'b000, text_q, 3'b000};

  // Subkey registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgKeyHi: key_hi_q <= cfg_wdata_i;
        CfgKeyLo: key_lo_q <= cfg_wdata_i;
        default:  key_hi_q <= key_hi_q;
      endcase
    end
  end

  // Sequencer: data multiply, length multiply, tag hand-off
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    aad_d       = aad_q;
    text_d      = text_q;
    last_d      = last_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q;
    mul_req     = '{start: 1'b0, x: '0};

    // drop the result beat once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          last_d = is_last_i;
          if (n_clip != '0) begin
            mul_req = '{start: 1'b1, x: acc_q ^ blk};
            if (section_i) begin
              text_d = sat_add(text_q, n_clip);
            end else begin
              aad_d = sat_add(aad_q, n_clip);
            end
            state_d = ST_MUL_DATA;
          end else if (is_last_i) begin
            mul_req = '{start: 1'b1, x: acc_q ^ len_blk};
            state_d = ST_MUL_LEN;
          end
        end
      end
      ST_MUL_DATA: begin
        if (mul_rsp.done) begin
          acc_d = mul_rsp.z;
          if (last_q) begin
            mul_req = '{start: 1'b1, x: mul_rsp.z ^ len_blk};
            state_d = ST_MUL_LEN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL_LEN: begin
        if (mul_rsp.done) begin
          acc_d   = mul_rsp.z;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register frees, then clear for the next message
        if (!out_valid_q || out_ready_i) begin
          tag_d       = acc_q;
          out_valid_d = 1'b1;
          acc_d       = '0;
          aad_d       = '0;
          text_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      aad_q       <= '0;
      text_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      aad_q       <= aad_d;
      text_q      <= text_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  gha_gfmul u_gfmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  ({key_hi_q, key_lo_q}),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign tag_hi_o    = tag_q[BlockBits-1:HalfBits];
  assign tag_lo_o    = tag_q[HalfBits-1:0];

  // Checks
  `GHA_ASSERT_SAME(a_ready_unit_free, in_ready_o, !mul_rsp.busy && !mul_rsp.done,
                   "accepting beats while the multiplier is active")
  `GHA_ASSERT_NEXT(a_empty_last_len, in_accept && is_last_i && (byte_count_i == '0),
                   state_q == ST_MUL_LEN, "empty last beat did not start the length multiply")
  `GHA_ASSERT_SAME(a_done_in_mul, mul_rsp.done,
                   (state_q == ST_MUL_DATA) || (state_q == ST_MUL_LEN),
                   "product returned outside a multiply state")

endmodule

FILE: src/gha_gfmul.sv
// ----------------------------------------------------------------------------
// GHASH GF(2^128) multiplier
// Iterative bit-reflected multiply by H, eight bits of X per cycle.
// ----------------------------------------------------------------------------
module gha_gfmul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gha_pkg::BlockBits-1:0] key_i,
  input  gha_pkg::mul_req_t             req_i,
  output gha_pkg::mul_rsp_t             rsp_o
);
  import gha_pkg::*;

  logic [BlockBits-1:0] x_q, x_d;
  logic [BlockBits-1:0] v_q, v_d;
  logic [BlockBits-1:0] z_q, z_d;
  logic [StepBits-1:0]  cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BlockBits-1:0] z_step, v_step;

  // Eight shift-and-add steps of the reflected multiply
  always_comb begin
    z_step = z_q;
    v_step = v_q;
    for (int k = 0; k < BitsPerCyc; k++) begin
      if (x_q[BlockBits-1-k]) begin
        z_step = z_step ^ v_step;
      end
      if (v_step[0]) begin
        v_step = {1'b0, v_step[BlockBits-1:1]} ^ {ReduceByte, {(BlockBits-8){1'b0}}};
      end else begin
        v_step = {1'b0, v_step[BlockBits-1:1]};
      end
    end
  end

  // Sequence: load on start, advance while busy, flag done after the last step
  always_comb begin
    x_d    = x_q;
    v_d    = v_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d    = req_i.x;
      v_d    = key_i;
      z_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d   = {x_q[BlockBits-1-BitsPerCyc:0], {BitsPerCyc{1'b0}}};
      v_d   = v_step;
      z_d   = z_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {StepBits{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    v_q <= v_d;
    z_q <= z_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.z    = z_q;

endmodule
